// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// concurrent assertion, also checked during reset
`define ASSERT_CLK_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== src/yoa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yoa_pkg
// Shared constants, types and the sigmoid table of the detection-layer
// output activation.
// ----------------------------------------------------------------------------
package yoa_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int MAX_ANCHORS_DEF = 9;

    localparam int PLANE_W  = 15;
    localparam int CLASS_W  = 10;
    localparam int ANCHOR_W = 4;
    localparam int THRESH_W = 13;
    localparam int LOC_W    = 14;
    localparam int ENTRY_W  = 11;
    localparam int COUNT_W  = 18;
    localparam int SIG_W    = 13;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_SIZE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_CLASSES = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_ANCHORS = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OBJ_THRESH  = 2'd3;

    localparam logic [PLANE_W-1:0]  PLANE_RST   = 15'd169;
    localparam logic [CLASS_W-1:0]  CLASS_RST   = 10'd80;
    localparam logic [ANCHOR_W-1:0] ANCHOR_RST  = 4'd3;
    localparam logic [THRESH_W-1:0] THRESH_RST  = 13'd2048;
    localparam logic [PLANE_W-1:0]  PLANE_MAX   = 15'd16384;
    localparam logic [ENTRY_W-1:0]  ENTRY_BASE  = 11'd5;
    localparam logic [ENTRY_W-1:0]  ENTRY_W_POS = 11'd2;
    localparam logic [ENTRY_W-1:0]  ENTRY_H_POS = 11'd3;
    localparam logic [ENTRY_W-1:0]  ENTRY_OBJ   = 11'd4;
    localparam logic [COUNT_W-1:0]  COUNT_MAX   = 18'h3FFFF;
    localparam logic [SIG_W-1:0]    FRAC_ONE    = 13'd4096;

    typedef struct packed {
        logic pass_thru;
        logic is_obj;
        logic last;
    } pos_t;

    // round(4096 * sigmoid(k/4)), k = 0..32
    function automatic logic [11:0] sig_tab(input logic [5:0] k);
        logic [11:0] v;
        case (k)
            6'd0:  v = 12'd2048;
            6'd1:  v = 12'd2303;
            6'd2:  v = 12'd2550;
            6'd3:  v = 12'd2782;
            6'd4:  v = 12'd2994;
            6'd5:  v = 12'd3184;
            6'd6:  v = 12'd3349;
            6'd7:  v = 12'd3490;
            6'd8:  v = 12'd3608;
            6'd9:  v = 12'd3705;
            6'd10: v = 12'd3785;
            6'd11: v = 12'd3850;
            6'd12: v = 12'd3902;
            6'd13: v = 12'd3943;
            6'd14: v = 12'd3976;
            6'd15: v = 12'd4002;
            6'd16: v = 12'd4022;
            6'd17: v = 12'd4038;
            6'd18: v = 12'd4051;
            6'd19: v = 12'd4061;
            6'd20: v = 12'd4069;
            6'd21: v = 12'd4075;
            6'd22: v = 12'd4079;
            6'd23: v = 12'd4083;
            6'd24: v = 12'd4086;
            6'd25: v = 12'd4088;
            6'd26: v = 12'd4090;
            6'd27: v = 12'd4091;
            6'd28: v = 12'd4092;
            6'd29: v = 12'd4093;
            6'd30: v = 12'd4094;
            6'd31: v = 12'd4094;
            default: v = 12'd4095;
        endcase
        return v;
    endfunction

endpackage

// ===== src/yoa_position.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yoa_position
// Location, entry and anchor counters; tags each accepted beat with its
// role in the layer.
// ----------------------------------------------------------------------------
module yoa_position (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [yoa_pkg::PLANE_W-1:0]   plane,
    input  logic [yoa_pkg::ENTRY_W-1:0]   entries,
    input  logic [yoa_pkg::ANCHOR_W-1:0]  anchors,
    output yoa_pkg::pos_t                 pos
);

    logic [yoa_pkg::LOC_W-1:0]    loc_reg, loc_next;
    logic [yoa_pkg::ENTRY_W-1:0]  entry_reg, entry_next;
    logic [yoa_pkg::ANCHOR_W-1:0] anchor_reg, anchor_next;
    logic [yoa_pkg::LOC_W:0]      loc_inc;
    logic [yoa_pkg::ENTRY_W:0]    entry_inc;
    logic [yoa_pkg::ANCHOR_W:0]   anchor_inc;
    logic                         loc_wrap, entry_wrap, anchor_wrap;

    always_comb begin
        loc_inc     = {1'b0, loc_reg} + 1'b1;
        entry_inc   = {1'b0, entry_reg} + 1'b1;
        anchor_inc  = {1'b0, anchor_reg} + 1'b1;
        loc_wrap    = loc_inc >= plane;
        entry_wrap  = loc_wrap && (entry_inc >= {1'b0, entries});
        anchor_wrap = entry_wrap && (anchor_inc >= {1'b0, anchors});

        loc_next    = loc_wrap ? '0 : loc_inc[yoa_pkg::LOC_W-1:0];
        entry_next  = entry_reg;
        anchor_next = anchor_reg;
        if (loc_wrap) begin
            entry_next = entry_wrap ? '0 : entry_inc[yoa_pkg::ENTRY_W-1:0];
        end
        if (entry_wrap) begin
            anchor_next = anchor_wrap ? '0 : anchor_inc[yoa_pkg::ANCHOR_W-1:0];
        end

        pos.pass_thru = (entry_reg == yoa_pkg::ENTRY_W_POS) ||
                        (entry_reg == yoa_pkg::ENTRY_H_POS);
        pos.is_obj    = entry_reg == yoa_pkg::ENTRY_OBJ;
        pos.last      = anchor_wrap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loc_reg    <= '0;
            entry_reg  <= '0;
            anchor_reg <= '0;
        end else if (step) begin
            loc_reg    <= loc_next;
            entry_reg  <= entry_next;
            anchor_reg <= anchor_next;
        end
    end

endmodule

// ===== src/yoa_sigmoid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yoa_sigmoid
// Logistic sigmoid in Q4.12 by table lookup with linear interpolation.
// ----------------------------------------------------------------------------
module yoa_sigmoid #(
    parameter int VALUE_WIDTH = yoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic signed [VALUE_WIDTH-1:0] x,
    output logic [yoa_pkg::SIG_W-1:0]     s,
    output logic [VALUE_WIDTH-1:0]        s_sat
);

    localparam int AW = (VALUE_WIDTH + 1 > 17) ? VALUE_WIDTH + 1 : 17;
    localparam int CW = (VALUE_WIDTH > yoa_pkg::SIG_W) ? VALUE_WIDTH : yoa_pkg::SIG_W;
    localparam logic [VALUE_WIDTH-1:0] MAXPOS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    logic signed [AW-1:0] x_ext;
    logic [AW-1:0]        a_full;
    logic [15:0]          a;
    logic [5:0]           idx;
    logic [9:0]           frac;
    logic [11:0]          t_lo, t_hi, y;
    logic [7:0]           diff;
    logic [17:0]          prod;
    logic [CW-1:0]        s_ext;

    always_comb begin
        x_ext  = AW'(x);
        a_full = x_ext[AW-1] ? AW'(-x_ext) : AW'(x_ext);
        a      = (a_full > AW'(32768)) ? 16'd32768 : a_full[15:0];
        idx    = a[15:10];
        frac   = a[9:0];
        t_lo   = yoa_pkg::sig_tab(idx);
        t_hi   = yoa_pkg::sig_tab(idx + 6'd1);
        diff   = 8'(t_hi - t_lo);
        prod   = 18'(diff * frac) + 18'd512;
        y      = (idx == 6'd32) ? t_lo : t_lo + 12'(prod[17:10]);
        s      = x[VALUE_WIDTH-1] ? yoa_pkg::FRAC_ONE - {1'b0, y} : {1'b0, y};
        s_ext  = CW'(s);
        s_sat  = (s_ext > CW'(MAXPOS)) ? MAXPOS : VALUE_WIDTH'(s_ext);
    end

endmodule

// ===== src/yoa_count.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yoa_count
// Objectness threshold test and saturating per-image detection count.
// ----------------------------------------------------------------------------
module yoa_count (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic                          is_obj,
    input  logic                          last,
    input  logic [yoa_pkg::SIG_W-1:0]     s,
    input  logic [yoa_pkg::THRESH_W-1:0]  thresh,
    output logic                          is_det,
    output logic [yoa_pkg::COUNT_W-1:0]   count
);

    logic [yoa_pkg::COUNT_W-1:0] running_reg, running_next;

    always_comb begin
        is_det = is_obj && (s > thresh);
        count  = running_reg;
        if (is_det && (running_reg != yoa_pkg::COUNT_MAX)) begin
            count = running_reg + 1'b1;
        end
        running_next = last ? '0 : count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= '0;
        end else if (step) begin
            running_reg <= running_next;
        end
    end

endmodule

// ===== src/yolo_output_activation_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yolo_output_activation_top
// Forward activation of a detection layer: sigmoid on x, y, objectness and
// classes, pass-through on w and h, objectness thresholding and counting.
// ----------------------------------------------------------------------------
// One feature value is taken per clock while the input side is not held, and
// every beat gives one result beat. A beat is registered at the input, goes
// through the sigmoid table and the threshold test, and lands in the output
// register that drives m_axis_tvalid; a stalled output holds the input side
// only once both registers are full. Values arrive anchor by anchor, entry
// by entry, location by location; tlast marks the final value of an image,
// after which the detection count starts over. Register writes belong
// between images while the block is idle.
// ----------------------------------------------------------------------------
module yolo_output_activation_top #(
    parameter int VALUE_WIDTH = yoa_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_ANCHORS = yoa_pkg::MAX_ANCHORS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [yoa_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [yoa_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // in_value
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // out_value, detection_count
    output logic [((VALUE_WIDTH+25)/8)*8-1:0]      m_axis_tdata,
    // is_objectness, is_detection
    output logic [1:0]                             m_axis_tuser,
    output logic                                   m_axis_tlast
);

    localparam int OUT_TDATA_W = ((VALUE_WIDTH + 25) / 8) * 8;

    logic [yoa_pkg::PLANE_W-1:0]  plane_size_reg;
    logic [yoa_pkg::CLASS_W-1:0]  num_classes_reg;
    logic [yoa_pkg::ANCHOR_W-1:0] num_anchors_reg;
    logic [yoa_pkg::THRESH_W-1:0] obj_thresh_reg;

    logic [yoa_pkg::PLANE_W-1:0]  plane;
    logic [yoa_pkg::ENTRY_W-1:0]  entries;
    logic [yoa_pkg::ANCHOR_W-1:0] anchors;

    logic                         s_accept, advance;
    yoa_pkg::pos_t                pos;
    logic                         s1_valid_reg, s1_valid_next;
    logic [VALUE_WIDTH-1:0]       s1_value_reg;
    yoa_pkg::pos_t                s1_pos_reg;

    logic [yoa_pkg::SIG_W-1:0]    sig;
    logic [VALUE_WIDTH-1:0]       sig_sat;
    logic                         det;
    logic [yoa_pkg::COUNT_W-1:0]  count;

    logic                         m_valid_reg, m_valid_next;
    logic [VALUE_WIDTH-1:0]       out_value_reg;
    logic                         obj_reg, det_reg, last_reg;
    logic [yoa_pkg::COUNT_W-1:0]  count_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_size_reg  <= yoa_pkg::PLANE_RST;
            num_classes_reg <= yoa_pkg::CLASS_RST;
            num_anchors_reg <= yoa_pkg::ANCHOR_RST;
            obj_thresh_reg  <= yoa_pkg::THRESH_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                yoa_pkg::REG_PLANE_SIZE:  plane_size_reg  <= cfg_wdata[yoa_pkg::PLANE_W-1:0];
                yoa_pkg::REG_NUM_CLASSES: num_classes_reg <= cfg_wdata[yoa_pkg::CLASS_W-1:0];
                yoa_pkg::REG_NUM_ANCHORS: num_anchors_reg <= cfg_wdata[yoa_pkg::ANCHOR_W-1:0];
                yoa_pkg::REG_OBJ_THRESH:  obj_thresh_reg  <= cfg_wdata[yoa_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        plane = plane_size_reg;
        if (plane_size_reg == '0) begin
            plane = yoa_pkg::PLANE_W'(1);
        end else if (plane_size_reg > yoa_pkg::PLANE_MAX) begin
            plane = yoa_pkg::PLANE_MAX;
        end
        anchors = num_anchors_reg;
        if (num_anchors_reg == '0) begin
            anchors = yoa_pkg::ANCHOR_W'(1);
        end else if (num_anchors_reg > yoa_pkg::ANCHOR_W'(MAX_ANCHORS)) begin
            anchors = yoa_pkg::ANCHOR_W'(MAX_ANCHORS);
        end
        entries = yoa_pkg::ENTRY_BASE + yoa_pkg::ENTRY_W'(num_classes_reg);
    end

    // handshake
    always_comb begin
        advance       = !m_valid_reg || m_axis_tready;
        s_axis_tready = !s1_valid_reg || advance;
        s_accept      = s_axis_tvalid && s_axis_tready;
        s1_valid_next = s_accept || (s1_valid_reg && !advance);
        m_valid_next  = advance ? s1_valid_reg : m_valid_reg;
    end

    yoa_position u_position (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (s_accept),
        .plane   (plane),
        .entries (entries),
        .anchors (anchors),
        .pos     (pos)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_value_reg <= s_axis_tdata[VALUE_WIDTH-1:0];
            s1_pos_reg   <= pos;
        end
    end

    yoa_sigmoid #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_sigmoid (
        .x     (s1_value_reg),
        .s     (sig),
        .s_sat (sig_sat)
    );

    yoa_count u_count (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance && s1_valid_reg),
        .is_obj  (s1_pos_reg.is_obj),
        .last    (s1_pos_reg.last),
        .s       (sig),
        .thresh  (obj_thresh_reg),
        .is_det  (det),
        .count   (count)
    );

    // output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_valid_reg) begin
            out_value_reg <= s1_pos_reg.pass_thru ? s1_value_reg : sig_sat;
            obj_reg       <= s1_pos_reg.is_obj;
            det_reg       <= det;
            count_reg     <= count;
            last_reg      <= s1_pos_reg.last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({count_reg, out_value_reg});
    assign m_axis_tuser  = {det_reg, obj_reg};
    assign m_axis_tlast  = last_reg;

endmodule

// ===== src/yoa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yoa_checker
// Port-level checks on the result stream of the output activation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module yoa_checker #(
    parameter int VALUE_WIDTH = yoa_pkg::VALUE_WIDTH_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((VALUE_WIDTH+25)/8)*8-1:0]   m_axis_tdata,
    input logic [1:0]                          m_axis_tuser,
    input logic                                m_axis_tlast
);

    logic [yoa_pkg::COUNT_W-1:0] beat_count;

    assign beat_count = m_axis_tdata[VALUE_WIDTH +: yoa_pkg::COUNT_W];

    // a detection only on an objectness beat
    `ASSERT_CLK(a_det_is_obj, aclk, aresetn,
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])

    // a detection beat carries a nonzero count
    `ASSERT_CLK(a_det_counted, aclk, aresetn,
        m_axis_tvalid && m_axis_tuser[1] |-> beat_count != '0)

    // no result right after reset
    `ASSERT_CLK_NR(a_reset_idle, aclk,
        !aresetn |=> !m_axis_tvalid)

    // stalled beat holds
    `ASSERT_CLK(a_stall_hold, aclk, aresetn,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))

endmodule

bind yolo_output_activation_top yoa_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_yoa_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the detection-layer output activation. A driver
// streams feature values from a queue, a scoreboard predicts the sigmoid,
// pass-through, threshold flag, per-image count and end-of-image mark of
// every accepted beat, and each result beat is compared field by field.
// Register settings change between phases, including in the middle of an
// image, and both stream sides idle and stall at varying rates.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_PERIOD  = 4;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [15:0]                 value;
        logic                        is_obj;
        logic                        is_det;
        logic [yoa_pkg::COUNT_W-1:0] count;
        logic                        last;
    } act_result_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [yoa_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [yoa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [15:0]                    s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [39:0]                    m_axis_tdata;
    logic [1:0]                     m_axis_tuser;
    logic                           m_axis_tlast;

    // register shadows
    logic [yoa_pkg::PLANE_W-1:0]  plane_reg  = yoa_pkg::PLANE_RST;
    logic [yoa_pkg::CLASS_W-1:0]  class_reg  = yoa_pkg::CLASS_RST;
    logic [yoa_pkg::ANCHOR_W-1:0] anchor_reg = yoa_pkg::ANCHOR_RST;
    logic [yoa_pkg::THRESH_W-1:0] thresh_reg = yoa_pkg::THRESH_RST;

    // layer position and per-image detection count
    logic [yoa_pkg::LOC_W-1:0]    loc_ctr = '0;
    logic [yoa_pkg::ENTRY_W-1:0]  entry_ctr = '0;
    logic [yoa_pkg::ANCHOR_W-1:0] anchor_ctr = '0;
    logic [yoa_pkg::COUNT_W-1:0]  det_running = '0;

    logic [15:0]   feature_queue[$];
    act_result_t   activation_queue[$];

    int unsigned logistic_lut [0:32] = '{
        2048, 2303, 2550, 2782, 2994, 3184, 3349, 3490,
        3608, 3705, 3785, 3850, 3902, 3943, 3976, 4002,
        4022, 4038, 4051, 4061, 4069, 4075, 4079, 4083,
        4086, 4088, 4090, 4091, 4092, 4093, 4094, 4094,
        4095
    };

    int  features_queued = 0;
    int  features_taken = 0;
    int  results_seen = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    int  src_idle_pct = 0;
    int  snk_stall_pct = 0;
    bit  in_fire = 1'b0;
    bit  hold_off = 1'b0;
    bit  squeeze_go = 1'b0;

    yolo_output_activation_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int unsigned logistic_q12(input int x);
        int unsigned mag;
        int unsigned idx;
        int unsigned frac;
        int unsigned y;
        mag = (x < 0) ? -x : x;
        if (mag > 32768) mag = 32768;
        idx = mag >> 10;
        frac = mag & 1023;
        if (idx >= 32) begin
            y = logistic_lut[32];
        end else begin
            y = logistic_lut[idx] +
                (((logistic_lut[idx + 1] - logistic_lut[idx]) * frac + 512) >> 10);
        end
        return (x < 0) ? (4096 - y) : y;
    endfunction

    task automatic predict_activation(input logic [15:0] raw);
        int plane_lim;
        int anchor_lim;
        int entry_lim;
        int x;
        int loc_n;
        int entry_n;
        int anchor_n;
        int unsigned sig;
        act_result_t r;
        plane_lim = int'(plane_reg);
        if (plane_lim < 1) plane_lim = 1;
        if (plane_lim > int'(yoa_pkg::PLANE_MAX)) plane_lim = int'(yoa_pkg::PLANE_MAX);
        anchor_lim = int'(anchor_reg);
        if (anchor_lim < 1) anchor_lim = 1;
        if (anchor_lim > yoa_pkg::MAX_ANCHORS_DEF) anchor_lim = yoa_pkg::MAX_ANCHORS_DEF;
        entry_lim = int'(yoa_pkg::ENTRY_BASE) + int'(class_reg);
        x = int'($signed(raw));
        r = '0;
        r.is_obj = (entry_ctr == yoa_pkg::ENTRY_OBJ);
        if (entry_ctr == yoa_pkg::ENTRY_W_POS || entry_ctr == yoa_pkg::ENTRY_H_POS) begin
            r.value = raw;
        end else begin
            sig = logistic_q12(x);
            r.value = sig[15:0];
            if (r.is_obj && sig > thresh_reg) begin
                r.is_det = 1'b1;
                if (det_running != yoa_pkg::COUNT_MAX) det_running = det_running + 1'b1;
            end
        end
        r.count = det_running;
        loc_n = int'(loc_ctr) + 1;
        entry_n = int'(entry_ctr);
        anchor_n = int'(anchor_ctr);
        if (loc_n >= plane_lim) begin
            loc_n = 0;
            entry_n = entry_n + 1;
            if (entry_n >= entry_lim) begin
                entry_n = 0;
                anchor_n = anchor_n + 1;
                if (anchor_n >= anchor_lim) begin
                    anchor_n = 0;
                    r.last = 1'b1;
                end
            end
        end
        loc_ctr = loc_n[yoa_pkg::LOC_W-1:0];
        entry_ctr = entry_n[yoa_pkg::ENTRY_W-1:0];
        anchor_ctr = anchor_n[yoa_pkg::ANCHOR_W-1:0];
        activation_queue.push_back(r);
        if (r.last) det_running = '0;
    endtask

    task automatic report_mismatch(input string field, input int unsigned got_v,
                                   input int unsigned want_v);
        if (error_count < 100) begin
            $display("result %0d: %s got %0d expected %0d", results_seen, field, got_v,
                     want_v);
        end
        error_count++;
    endtask

    // scoreboard: register shadows, result check, prediction of accepted beats
    always @(posedge aclk) begin
        act_result_t got;
        act_result_t want;
        if (!aresetn) begin
            in_fire = 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    yoa_pkg::REG_PLANE_SIZE:  plane_reg = cfg_wdata[yoa_pkg::PLANE_W-1:0];
                    yoa_pkg::REG_NUM_CLASSES: class_reg = cfg_wdata[yoa_pkg::CLASS_W-1:0];
                    yoa_pkg::REG_NUM_ANCHORS: anchor_reg = cfg_wdata[yoa_pkg::ANCHOR_W-1:0];
                    yoa_pkg::REG_OBJ_THRESH:  thresh_reg = cfg_wdata[yoa_pkg::THRESH_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.value = m_axis_tdata[15:0];
                got.count = m_axis_tdata[16 +: yoa_pkg::COUNT_W];
                got.is_obj = m_axis_tuser[0];
                got.is_det = m_axis_tuser[1];
                got.last = m_axis_tlast;
                if (activation_queue.size() == 0) begin
                    report_mismatch("beat with nothing pending, out_value",
                                    32'(got.value), 0);
                end else begin
                    want = activation_queue.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("out_value", 32'(got.value), 32'(want.value));
                    if (got.is_obj !== want.is_obj)
                        report_mismatch("is_objectness", 32'(got.is_obj), 32'(want.is_obj));
                    if (got.is_det !== want.is_det)
                        report_mismatch("is_detection", 32'(got.is_det), 32'(want.is_det));
                    if (got.count !== want.count)
                        report_mismatch("detection_count", 32'(got.count), 32'(want.count));
                    if (got.last !== want.last)
                        report_mismatch("last_of_image", 32'(got.last), 32'(want.last));
                end
                results_seen++;
            end
            in_fire = s_axis_tvalid && s_axis_tready;
            if (in_fire) begin
                predict_activation(s_axis_tdata);
                features_taken++;
            end
        end
    end

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (feature_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_axis_tdata <= feature_queue.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side backpressure
    always @(negedge aclk) begin
        m_axis_tready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
    end

    // long output stall so the block fills and stalls its input
    initial begin
        wait (squeeze_go);
        @(negedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [yoa_pkg::CFG_ADDR_W-1:0] addr, input int data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data[yoa_pkg::CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drain();
        while (features_taken != features_queued || activation_queue.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic push_feature(input logic [15:0] v);
        feature_queue.push_back(v);
        features_queued++;
    endtask

    function automatic logic [15:0] random_feature();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35) return 16'($urandom);
        if (pick < 80) return 16'($urandom_range(24576) - 12288);
        if (pick < 90) return 16'($urandom_range(40) - 20);
        case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'hffff;
        endcase
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 74; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 74; end
            default: begin src_idle_pct = 29; snk_stall_pct = 29; end
        endcase
    endtask

    task automatic run_phase(input int plane, input int classes, input int anchors,
                             input int thresh, input int mode, input int beats,
                             input bit squeeze);
        wait_drain();
        write_reg(yoa_pkg::REG_PLANE_SIZE, plane);
        write_reg(yoa_pkg::REG_NUM_CLASSES, classes);
        write_reg(yoa_pkg::REG_NUM_ANCHORS, anchors);
        write_reg(yoa_pkg::REG_OBJ_THRESH, thresh);
        set_idling(mode);
        @(posedge aclk);
        for (int k = 0; k < beats; k++) push_feature(random_feature());
        if (squeeze) squeeze_go = 1'b1;
    endtask

    initial begin
        int p;
        int c;
        int a;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: x plane, sigmoid extremes and saturation
        @(posedge aclk);
        push_feature(16'h8000);
        push_feature(16'h7fff);
        push_feature(16'h0000);
        push_feature(16'hffff);
        push_feature(16'h0001);
        push_feature(16'h1000);

        // shrink the layer mid-image: location counter lies past the new plane
        wait_drain();
        write_reg(yoa_pkg::REG_PLANE_SIZE, 3);
        write_reg(yoa_pkg::REG_NUM_CLASSES, 1);
        write_reg(yoa_pkg::REG_NUM_ANCHORS, 1);
        write_reg(yoa_pkg::REG_OBJ_THRESH, 2048);
        @(posedge aclk);
        push_feature(16'hf800);
        push_feature(16'h07ff);
        push_feature(16'hf000);
        push_feature(16'h3000);
        push_feature(16'h8000);  // w, h pass through
        push_feature(16'h7fff);
        push_feature(16'hffff);
        push_feature(16'h0000);
        push_feature(16'h0001);
        push_feature(16'hcfc7);
        push_feature(16'h0000);  // objectness at, just at and just above threshold
        push_feature(16'h0001);
        push_feature(16'h0003);
        push_feature(16'h8001);
        push_feature(16'h2000);
        push_feature(16'he000);

        run_phase(4, 3, 2, 2048, 0, 192, 1'b0);
        run_phase(0, 0, 1, 0, 1, 100, 1'b0);
        run_phase(1, 1023, 0, 1024, 2, 300, 1'b0);
        run_phase(2, 2, 15, 4096, 3, 126, 1'b0);
        run_phase(32767, 0, 9, 8191, 0, 40, 1'b0);
        run_phase(3, 5, 3, 3000, 0, 180, 1'b1);
        run_phase(1, 2, 1, $urandom_range(4200), 3, 140, 1'b0);
        for (int k = 0; k < 3; k++) begin
            p = $urandom_range(1, 6);
            c = $urandom_range(0, 4);
            a = $urandom_range(1, 4);
            run_phase(p, c, a, $urandom_range(4200), $urandom_range(3), p * (5 + c) * a,
                      1'b0);
        end

        wait_drain();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
